>>> hdl/wcrp_pkg.sv
package wcrp_pkg;

	// Phase resolution of the rotation angles (full turn = 2^PHASE_BITS)
	localparam int PHASE_BITS = 10;
	localparam int QTR_BITS   = PHASE_BITS - 2;
	localparam int QUARTER    = 1 << QTR_BITS;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Field widths
	localparam int ANGLE_W = 10;
	localparam int COORD_W = 12;
	localparam int EDGE_W  = 4;
	localparam int SINE_W  = 16;
	localparam int OPA_W   = 18;
	localparam int PROD_W  = OPA_W + SINE_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int Q8_W    = 18;
	localparam int NUM_W   = 24;
	localparam int DEN_W   = 17;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	// Projection constants: PERSP_NUM is a plain scale, PERSP_DIST is in Q8
	localparam int PERSP_NUM  = 100;
	localparam int PERSP_DIST = 200 * 256;

	// Shared multiplier-accumulator operations
	localparam logic [1:0] MAC_LOAD = 2'd0;
	localparam logic [1:0] MAC_ADD  = 2'd1;
	localparam logic [1:0] MAC_SUB  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_HALF_SIZE = 2'd0;
	localparam logic [1:0] REG_CENTER_X  = 2'd1;
	localparam logic [1:0] REG_CENTER_Y  = 2'd2;

	typedef logic signed [SINE_W-1:0] sine_t;

	typedef struct packed {
		logic                    valid;
		logic [1:0]              mode;
		logic signed [OPA_W-1:0] a;
		logic signed [SINE_W-1:0] b;
	} mac_req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// Quarter-wave sine in Q15, Taylor sum in Q30, built at elaboration
	function automatic logic [(QUARTER+1)*SINE_W-1:0] build_sine();
		logic [(QUARTER+1)*SINE_W-1:0] tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		tab = '0;
		for (int r = 0; r <= QUARTER; r++) begin
			x = (64'(r) * HALF_PI_Q30) / QUARTER;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 6; n++) begin
				term = (term * x2) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if ((n % 2) == 1)
					sum = (sum >= term) ? sum - term : 64'd0;
				else
					sum = sum + term;
			end
			q = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
			if (q > 64'd32767)
				q = 64'd32767;
			tab[r*SINE_W +: SINE_W] = q[SINE_W-1:0];
		end
		return tab;
	endfunction

	localparam logic [(QUARTER+1)*SINE_W-1:0] SINE_TAB = build_sine();

	// Full-wave sine from the quarter table by mirroring and negation
	function automatic sine_t sin_q15(logic [PHASE_BITS-1:0] p);
		logic [1:0]          quad;
		logic [QTR_BITS:0]   r;
		logic [SINE_W-1:0]   mag;
		quad = p[PHASE_BITS-1 -: 2];
		r = {1'b0, p[QTR_BITS-1:0]};
		if (quad[0])
			r = (QTR_BITS+1)'(QUARTER) - r;
		mag = SINE_TAB[r*SINE_W +: SINE_W];
		return quad[1] ? -$signed(mag) : $signed(mag);
	endfunction

	// Corner numbers at the two ends of each edge
	function automatic logic [2:0] edge_end(logic [EDGE_W-1:0] e, logic k);
		logic [2:0] a;
		logic [2:0] b;
		case (e)
			4'd0: begin a = 3'd0; b = 3'd1; end
			4'd1: begin a = 3'd1; b = 3'd2; end
			4'd2: begin a = 3'd2; b = 3'd3; end
			4'd3: begin a = 3'd3; b = 3'd0; end
			4'd4: begin a = 3'd4; b = 3'd5; end
			4'd5: begin a = 3'd5; b = 3'd6; end
			4'd6: begin a = 3'd6; b = 3'd7; end
			4'd7: begin a = 3'd7; b = 3'd4; end
			4'd8: begin a = 3'd0; b = 3'd4; end
			4'd9: begin a = 3'd1; b = 3'd5; end
			4'd10: begin a = 3'd2; b = 3'd6; end
			4'd11: begin a = 3'd3; b = 3'd7; end
			default: begin a = 3'd0; b = 3'd0; end
		endcase
		return k ? b : a;
	endfunction

endpackage

>>> hdl/wcrp_mac.sv
module wcrp_mac
	import wcrp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_req_t                req,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     valid_s1;
	logic [1:0]               mode_s1;
	logic signed [ACC_W-1:0]  acc_q;

	// Track which multiply is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_s1 <= MAC_LOAD;
		end else begin
			valid_s1 <= req.valid;
			mode_s1 <= req.mode;
		end
	end

	// Multiply, then accumulate the registered product in the next cycle
	always_ff @(posedge clk) begin
		prod_s1 <= req.a * req.b;
		if (valid_s1) begin
			case (mode_s1)
				MAC_LOAD: acc_q <= ACC_W'(prod_s1);
				MAC_ADD: acc_q <= acc_q + ACC_W'(prod_s1);
				MAC_SUB: acc_q <= acc_q - ACC_W'(prod_s1);
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign acc = acc_q;

endmodule

>>> hdl/wcrp_div.sv
module wcrp_div
	import wcrp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     quot_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W:0]       shifted;
	logic                 ge;

	// One restoring step: bring down the next numerator bit
	assign shifted = {rem_q, quot_q[NUM_W-1]};
	assign ge = shifted >= {1'b0, den_q};

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in quotient bits, keep the partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> hdl/wireframe_cube_rotate_project_core.sv
// Channel   Direction  Signals                               Contents
// s_axis    in         s_tvalid s_tready s_tdata[23:0]       two rotation phases
// m_axis    out        m_tvalid m_tready m_tdata[47:0]       erase/draw segments
//                      m_tuser[4:0] m_tlast
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// Each request turns every corner on the shared multiply-accumulate unit and
// runs two divides per corner on the serial divider, then emits two segments
// per edge; output stalls lengthen a request. s_tready is high only while idle.
// Reset clears control state, the stored old endpoints and the registers to
// their defaults. Output stalls hold the sequencer in place; configuration
// writes are always taken.
module wireframe_cube_rotate_project_core
	import wcrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [9:0] angle_x_phase, [19:10] angle_y_phase
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // seg_x1, seg_y1, seg_x2, seg_y2 (12 bits each)
	output logic [4:0]  m_tuser,   // [0] pen, [4:1] edge_number
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ROT      = 3'd1;
	localparam logic [2:0] S_DIV_GO   = 3'd2;
	localparam logic [2:0] S_DIV_WAIT = 3'd3;
	localparam logic [2:0] S_EDGE_A   = 3'd4;
	localparam logic [2:0] S_EDGE_B   = 3'd5;
	localparam logic [2:0] S_OUT_OLD  = 3'd6;
	localparam logic [2:0] S_OUT_NEW  = 3'd7;

	localparam int SEG_W = 4 * COORD_W;

	logic [2:0]  state_q;
	logic [2:0]  corner_q;
	logic [3:0]  st_q;
	logic        axis_q;
	logic [EDGE_W-1:0] edge_q;
	logic [6:0]  half_size_q;
	logic [9:0]  center_x_q;
	logic [9:0]  center_y_q;

	sine_t sa_q, ca_q, sb_q, cb_q;
	logic signed [Q8_W-1:0] y1_q, z1_q, z2_q, x2_q;
	logic signed [COORD_W-1:0] proj_x_q [8];
	logic signed [COORD_W-1:0] proj_y_q [8];
	logic [SEG_W-1:0] old_q [12];
	logic [SEG_W-1:0] new_q;
	logic [SEG_W-1:0] out_data_q;
	logic [4:0]  out_user_q;
	logic        out_last_q;
	logic        out_valid_q;

	logic [PHASE_BITS-1:0] ax_p, ay_p;
	logic signed [OPA_W-1:0] yv, zv, xq;
	mac_req_t mac_req;
	logic signed [ACC_W-1:0] acc;
	div_req_t div_req;
	logic div_done;
	logic [NUM_W-1:0] quot;

	logic signed [Q8_W-1:0] v_sel;
	logic signed [NUM_W:0]  num_s;
	logic                   num_neg;
	logic signed [Q8_W:0]   den_s;
	logic [9:0]             cen_sel;
	logic signed [NUM_W+1:0] sum_s;
	logic signed [COORD_W-1:0] proj_val;

	// Truncate toward zero from the accumulator into Q8
	function automatic logic signed [Q8_W-1:0] tz_q8(logic signed [ACC_W-1:0] v, logic sh15);
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] r;
		logic [Q8_W-1:0]  res;
		mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		r = sh15 ? (mag >> 15) : (mag >> 7);
		res = r[Q8_W-1:0];
		return v[ACC_W-1] ? -$signed(res) : $signed(res);
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign ax_p = PHASE_BITS'(s_tdata[ANGLE_W-1:0]);
	assign ay_p = PHASE_BITS'(s_tdata[2*ANGLE_W-1:ANGLE_W]);

	// Corner coordinates from the sign pattern of the corner number
	always_comb begin
		xq = (corner_q[0] ^ corner_q[1]) ? OPA_W'({half_size_q, 8'd0})
			: -OPA_W'({half_size_q, 8'd0});
		yv = corner_q[1] ? OPA_W'(half_size_q) : -OPA_W'(half_size_q);
		zv = corner_q[2] ? OPA_W'(half_size_q) : -OPA_W'(half_size_q);
	end

	// Select the operands of the shared multiplier for each step
	always_comb begin
		mac_req.valid = (state_q == S_ROT);
		mac_req.mode = MAC_LOAD;
		mac_req.a = yv;
		mac_req.b = ca_q;
		case (st_q)
			4'd0: begin mac_req.a = yv; mac_req.b = ca_q; mac_req.mode = MAC_LOAD; end
			4'd1: begin mac_req.a = zv; mac_req.b = sa_q; mac_req.mode = MAC_SUB; end
			4'd2: begin mac_req.a = yv; mac_req.b = sa_q; mac_req.mode = MAC_LOAD; end
			4'd3: begin mac_req.a = zv; mac_req.b = ca_q; mac_req.mode = MAC_ADD; end
			4'd6: begin mac_req.a = z1_q; mac_req.b = cb_q; mac_req.mode = MAC_LOAD; end
			4'd7: begin mac_req.a = xq; mac_req.b = sb_q; mac_req.mode = MAC_SUB; end
			4'd8: begin mac_req.a = z1_q; mac_req.b = sb_q; mac_req.mode = MAC_LOAD; end
			4'd9: begin mac_req.a = xq; mac_req.b = cb_q; mac_req.mode = MAC_ADD; end
			default: mac_req.valid = 1'b0;
		endcase
	end

	wcrp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.acc    (acc)
	);

	// Numerator and divisor of the perspective divide
	always_comb begin
		v_sel = axis_q ? y1_q : x2_q;
		cen_sel = axis_q ? center_y_q : center_x_q;
		num_s = (NUM_W+1)'(v_sel) * (NUM_W+1)'(PERSP_NUM);
		num_neg = num_s[NUM_W];
		den_s = (Q8_W+1)'(z2_q) + (Q8_W+1)'(PERSP_DIST);
		if (den_s < (Q8_W+1)'(1))
			den_s = (Q8_W+1)'(1);
		div_req.start = (state_q == S_DIV_GO);
		div_req.num = num_neg ? NUM_W'(-num_s) : NUM_W'(num_s);
		div_req.den = den_s[DEN_W-1:0];
	end

	wcrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (quot)
	);

	// Add the center and saturate to the screen range
	always_comb begin
		sum_s = (NUM_W+2)'({1'b0, cen_sel}) + (num_neg ? -(NUM_W+2)'({2'b0, quot})
			: (NUM_W+2)'({2'b0, quot}));
		if (sum_s > (NUM_W+2)'(2047))
			proj_val = 12'sd2047;
		else if (sum_s < -(NUM_W+2)'(2048))
			proj_val = -12'sd2048;
		else
			proj_val = sum_s[COORD_W-1:0];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_size_q <= 7'd100;
			center_x_q <= 10'd320;
			center_y_q <= 10'd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HALF_SIZE: half_size_q <= cfg_data[6:0];
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: rotate, divide, then emit erase and draw for each edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			corner_q <= '0;
			st_q <= '0;
			axis_q <= 1'b0;
			edge_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 12; i++)
				old_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						corner_q <= '0;
						st_q <= '0;
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					st_q <= st_q + 1'b1;
					if (st_q == 4'd11) begin
						axis_q <= 1'b0;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						if (!axis_q) begin
							axis_q <= 1'b1;
							state_q <= S_DIV_GO;
						end else if (corner_q == 3'd7) begin
							edge_q <= '0;
							state_q <= S_EDGE_A;
						end else begin
							corner_q <= corner_q + 1'b1;
							st_q <= '0;
							state_q <= S_ROT;
						end
					end
				end
				S_EDGE_A: state_q <= S_EDGE_B;
				S_EDGE_B: begin
					out_valid_q <= 1'b1;
					state_q <= S_OUT_OLD;
				end
				S_OUT_OLD: begin
					if (m_tready)
						state_q <= S_OUT_NEW;
				end
				S_OUT_NEW: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						old_q[edge_q] <= new_q;
						if (edge_q == EDGE_W'(11)) begin
							state_q <= S_IDLE;
						end else begin
							edge_q <= edge_q + 1'b1;
							state_q <= S_EDGE_A;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: sines, turned coordinates, projections, output
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			sa_q <= sin_q15(ax_p);
			ca_q <= sin_q15(ax_p + PHASE_BITS'(QUARTER));
			sb_q <= sin_q15(ay_p);
			cb_q <= sin_q15(ay_p + PHASE_BITS'(QUARTER));
		end
		if (state_q == S_ROT) begin
			case (st_q)
				4'd3: y1_q <= tz_q8(acc, 1'b0);
				4'd5: z1_q <= tz_q8(acc, 1'b0);
				4'd9: z2_q <= tz_q8(acc, 1'b1);
				4'd11: x2_q <= tz_q8(acc, 1'b1);
				default: ;
			endcase
		end
		if (state_q == S_DIV_WAIT && div_done) begin
			if (axis_q)
				proj_y_q[corner_q] <= proj_val;
			else
				proj_x_q[corner_q] <= proj_val;
		end
		case (state_q)
			S_EDGE_A: begin
				new_q[COORD_W-1:0] <= proj_x_q[edge_end(edge_q, 1'b0)];
				new_q[2*COORD_W-1:COORD_W] <= proj_y_q[edge_end(edge_q, 1'b0)];
			end
			S_EDGE_B: begin
				new_q[3*COORD_W-1:2*COORD_W] <= proj_x_q[edge_end(edge_q, 1'b1)];
				new_q[4*COORD_W-1:3*COORD_W] <= proj_y_q[edge_end(edge_q, 1'b1)];
				out_data_q <= old_q[edge_q];
				out_user_q <= {edge_q, 1'b0};
				out_last_q <= 1'b0;
			end
			S_OUT_OLD: begin
				if (m_tready) begin
					out_data_q <= new_q;
					out_user_q <= {edge_q, 1'b1};
					out_last_q <= (edge_q == EDGE_W'(11));
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;
	assign m_tlast = out_last_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import wcrp_pkg::*;

	// Index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic signed [11:0] x1;
		logic signed [11:0] y1;
		logic signed [11:0] x2;
		logic signed [11:0] y2;
		logic               pen;
		logic [3:0]         edge_no;
		logic               last;
	} segment_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;

	// cube model state
	int unsigned    cube_half;
	int unsigned    cube_cx;
	int unsigned    cube_cy;
	int             prev_ends[48];
	segment_t       pending_segs[$];
	int             error_count;
	bit             idle_on;

	wireframe_cube_rotate_project_core dut (.*);

	always #6 clk = ~clk;

	// Sine table, computed independently in Q30 Taylor form
	function automatic longint quarter_sin(int unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned q;
		x = (longint'(r) * 64'd1686629713) / QUARTER;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 6; n++) begin
			term = (term * x2) >> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				sum = (sum >= term) ? sum - term : 0;
			else
				sum = sum + term;
		end
		q = (sum * 32767 + (64'd1 << 29)) >> 30;
		if (q > 32767)
			q = 32767;
		return longint'(q);
	endfunction

	function automatic longint phase_sin(int unsigned p);
		int unsigned quad;
		int unsigned r;
		longint      mag;
		p = p & ((1 << PHASE_BITS) - 1);
		quad = p >> (PHASE_BITS - 2);
		r = p & (QUARTER - 1);
		if (quad & 1)
			r = QUARTER - r;
		mag = quarter_sin(r);
		return (quad & 2) ? -mag : mag;
	endfunction

	function automatic longint trunc_shift(longint v, int sh);
		if (v < 0)
			return -((-v) >>> sh);
		return v >>> sh;
	endfunction

	function automatic int persp(longint v, longint z, int unsigned c);
		longint den;
		longint s;
		den = z + 200 * 256;
		if (den < 1)
			den = 1;
		s = longint'(c) + (v * 100) / den;
		if (s > 2047)
			s = 2047;
		if (s < -2048)
			s = -2048;
		return int'(s);
	endfunction

	// Turn the cube, project it and queue the erase/draw segments
	task automatic predict_frame(int unsigned ax, int unsigned ay);
		longint sa;
		longint ca;
		longint sb;
		longint cb;
		longint h;
		longint x;
		longint y;
		longint z;
		longint yr;
		longint zr;
		longint cx[8];
		longint cy[8];
		longint cz[8];
		int     nw[4];
		int     corner;
		segment_t sg;
		sa = phase_sin(ax);
		ca = phase_sin(ax + QUARTER);
		sb = phase_sin(ay);
		cb = phase_sin(ay + QUARTER);
		h = cube_half;
		for (int i = 0; i < 8; i++) begin
			x = ((i == 1 || i == 2 || i == 5 || i == 6) ? 1 : -1) * h;
			y = ((i == 2 || i == 3 || i == 6 || i == 7) ? 1 : -1) * h;
			z = (i >= 4 ? 1 : -1) * h;
			yr = trunc_shift(y * ca - z * sa, 7);
			zr = trunc_shift(y * sa + z * ca, 7);
			cz[i] = trunc_shift(zr * cb - x * 256 * sb, 15);
			cx[i] = trunc_shift(zr * sb + x * 256 * cb, 15);
			cy[i] = yr;
		end
		for (int e = 0; e < 12; e++) begin
			for (int k = 0; k < 2; k++) begin
				if (e < 8)
					corner = (e & 4) | (((e & 3) + k) & 3);
				else
					corner = (e - 8) + 4 * k;
				nw[2 * k] = persp(cx[corner], cz[corner], cube_cx);
				nw[2 * k + 1] = persp(cy[corner], cz[corner], cube_cy);
			end
			sg.x1 = 12'(prev_ends[4 * e]); sg.y1 = 12'(prev_ends[4 * e + 1]);
			sg.x2 = 12'(prev_ends[4 * e + 2]); sg.y2 = 12'(prev_ends[4 * e + 3]);
			sg.pen = 1'b0; sg.edge_no = 4'(e); sg.last = 1'b0;
			pending_segs.push_back(sg);
			sg.x1 = 12'(nw[0]); sg.y1 = 12'(nw[1]);
			sg.x2 = 12'(nw[2]); sg.y2 = 12'(nw[3]);
			sg.pen = 1'b1; sg.last = (e == 11);
			pending_segs.push_back(sg);
			for (int j = 0; j < 4; j++)
				prev_ends[4 * e + j] = nw[j];
		end
	endtask

	// Send one angle request, idling at random beforehand
	task automatic send_angles(int unsigned ax, int unsigned ay);
		while (idle_on && $urandom_range(99) < 37)
			@(posedge clk);
		s_tvalid <= 1;
		s_tdata <= {4'd0, ay[9:0], ax[9:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_frame(ax, ay);
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	task automatic drain_segments();
		while (pending_segs.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		case (idx)
			REG_HALF_SIZE: cube_half = 32'(val[6:0]);
			REG_CENTER_X:  cube_cx = 32'(val);
			REG_CENTER_Y:  cube_cy = 32'(val);
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Quadrant edges, full-width phases and default registers
	task automatic test_angle_extremes();
		int unsigned phases[8] = '{0, 256, 512, 768, 1023, 1, 255, 511};
		for (int i = 0; i < 8; i++)
			send_angles(phases[i], phases[7 - i]);
		send_angles(10'h3FF, 10'h2AA);
		send_angles(10'h155, 10'h000);
		drain_segments();
	endtask

	// Register extremes, unused index, zero half size and deep saturation
	task automatic test_register_extremes();
		write_reg(REG_HALF_SIZE, 10'd0);
		send_angles(37, 900);
		drain_segments();
		write_reg(REG_HALF_SIZE, 10'h3FF);
		write_reg(REG_CENTER_X, 10'd1023);
		write_reg(REG_CENTER_Y, 10'd0);
		send_angles(128, 128);
		send_angles(640, 384);
		drain_segments();
		write_reg(REG_HALF_SIZE, 10'd1);
		write_reg(REG_CENTER_X, 10'd0);
		write_reg(REG_CENTER_Y, 10'd1023);
		write_reg(REG_UNUSED, 10'h2A5);
		send_angles(300, 700);
		drain_segments();
		write_reg(REG_HALF_SIZE, 10'd100);
		write_reg(REG_CENTER_X, 10'h155);
		write_reg(REG_CENTER_Y, 10'h2AA);
		send_angles(200, 50);
		drain_segments();
	endtask

	// Random angles over several register settings
	task automatic test_random_frames();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_HALF_SIZE, 10'($urandom_range(100, 1)));
			write_reg(REG_CENTER_X, 10'($urandom_range(1023)));
			write_reg(REG_CENTER_Y, 10'($urandom_range(1023)));
			idle_on = (ph != 2);
			for (int i = 0; i < 40; i++)
				send_angles($urandom_range(1023), $urandom_range(1023));
			drain_segments();
		end
		idle_on = 1;
	endtask

	// Sink side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 0;
		else
			m_tready <= !idle_on || ($urandom_range(99) >= 37);
	end

	// Compare each segment against the oldest expectation
	always @(posedge clk) begin
		segment_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_segs.size() == 0) begin
				$error("unexpected segment %h %h %b", m_tdata, m_tuser, m_tlast);
				error_count++;
			end else begin
				want = pending_segs.pop_front();
				if (m_tdata[11:0] !== want.x1) begin
					$error("seg_x1 exp %0d got %0d", want.x1, $signed(m_tdata[11:0]));
					error_count++;
				end
				if (m_tdata[23:12] !== want.y1) begin
					$error("seg_y1 exp %0d got %0d", want.y1, $signed(m_tdata[23:12]));
					error_count++;
				end
				if (m_tdata[35:24] !== want.x2) begin
					$error("seg_x2 exp %0d got %0d", want.x2, $signed(m_tdata[35:24]));
					error_count++;
				end
				if (m_tdata[47:36] !== want.y2) begin
					$error("seg_y2 exp %0d got %0d", want.y2, $signed(m_tdata[47:36]));
					error_count++;
				end
				if (m_tuser[0] !== want.pen) begin
					$error("pen exp %0d got %0d", want.pen, m_tuser[0]);
					error_count++;
				end
				if (m_tuser[4:1] !== want.edge_no) begin
					$error("edge_number exp %0d got %0d", want.edge_no, m_tuser[4:1]);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last exp %0d got %0d", want.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		cube_half = 100;
		cube_cx = 320;
		cube_cy = 100;
		error_count = 0;
		idle_on = 1;
		foreach (prev_ends[i])
			prev_ends[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_angle_extremes();
		test_register_extremes();
		test_random_frames();
		if (pending_segs.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#50ms;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
